/* rtl/fixed_point_q24_8_alu_unit_macros.svh */
// Assertion macros for the Q24.8 fixed-point ALU.
// Used by files that check their own pipeline; needs clk_i and rst_ni in scope.
`ifndef FIXED_POINT_Q24_8_ALU_UNIT_MACROS_SVH
`define FIXED_POINT_Q24_8_ALU_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define FPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition holds whenever an item leaves the block.
`define FPA_ASSERT_OUT(lbl, cond, msg) \
  `FPA_ASSERT(lbl, (out_o.valid |-> (cond)), msg)

`endif

/* rtl/fpa_pkg.sv */
// Shared types and constants for the fixed-point ALU.
// No dependencies.
`timescale 1ns / 1ps

package fpa_pkg;

  typedef enum logic [3:0] {
    ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_INC, ACT_DEC,
    ACT_GT, ACT_LT, ACT_GE, ACT_LE, ACT_EQ, ACT_NE,
    ACT_MIN, ACT_MAX, ACT_FROM_INT, ACT_TO_INT
  } fpa_action_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_SAT      = 2'd2
  } fpa_status_e;

  localparam logic signed [31:0] MAX_RAW = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN_RAW = 32'sh8000_0000;

  // Control and finished-result fields that travel with each item
  typedef struct packed {
    logic               valid;
    fpa_action_e        action;
    logic               neg;
    logic signed [31:0] res;
    logic               flag;
    fpa_status_e        status;
  } fpa_ctrl_t;

endpackage

/* rtl/fpa_if.sv */
// Valid/ready channel interfaces for the fixed-point ALU.
// No dependencies.
`timescale 1ns / 1ps

interface fpa_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         action;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source (output valid, action, operand_a, operand_b, input ready);
  modport sink   (input valid, action, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_raw;
  logic               compare_flag;
  logic [1:0]         status;
  modport source (output valid, result_raw, compare_flag, status, input ready);
  modport sink   (input valid, result_raw, compare_flag, status, output ready);
endinterface

/* rtl/fpa_front.sv */
// Front stages: operand magnitudes and product, then all simple operations
// and divider setup. Depends on fpa_pkg.
`timescale 1ns / 1ps

module fpa_front import fpa_pkg::*; #(
  parameter int FRAC_BITS = 8,
  parameter int NW        = 40
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [3:0]         action_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output fpa_ctrl_t          ctrl_o,
  output logic [NW-1:0]      w_o,
  output logic [31:0]        nb_o
);

  localparam logic [63:0] HALF = (64'd1 << FRAC_BITS) >> 1;

  // Stage A registers
  logic               valid_a_q;
  fpa_action_e        act_a_q;
  logic signed [31:0] a_a_q, b_a_q;
  logic [31:0]        amag_a_q, bmag_a_q;
  logic [63:0]        prod_a_q;

  logic [31:0] amag_in, bmag_in;
  assign amag_in = a_i[31] ? 32'(-a_i) : 32'(a_i);
  assign bmag_in = b_i[31] ? 32'(-b_i) : 32'(b_i);

  // Capture operands and the unsigned magnitude product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      act_a_q  <= fpa_action_e'(action_i);
      a_a_q    <= a_i;
      b_a_q    <= b_i;
      amag_a_q <= amag_in;
      bmag_a_q <= bmag_in;
      prod_a_q <= amag_in * bmag_in;
    end
  end

  // Stage B logic
  fpa_ctrl_t          ctrl_d, ctrl_q;
  logic [NW-1:0]      w_q;
  logic [31:0]        nb_q;
  logic signed [32:0] addend, sum;
  logic [63:0]        rnd;
  logic               pneg;
  logic signed [63:0] fi;

  always_comb begin
    unique case (act_a_q)
      ACT_SUB: addend = -33'(b_a_q);
      ACT_INC: addend = 33'sd1;
      ACT_DEC: addend = -33'sd1;
      default: addend = 33'(b_a_q);
    endcase
  end

  assign sum  = 33'(a_a_q) + addend;
  assign rnd  = (prod_a_q + HALF) >> FRAC_BITS;
  assign pneg = a_a_q[31] ^ b_a_q[31];
  assign fi   = 64'(a_a_q) <<< FRAC_BITS;

  // Compute every operation except the divide quotient
  always_comb begin
    ctrl_d        = '0;
    ctrl_d.valid  = valid_a_q;
    ctrl_d.action = act_a_q;
    ctrl_d.neg    = pneg;
    ctrl_d.status = ST_OK;
    unique case (act_a_q)
      ACT_ADD, ACT_SUB, ACT_INC, ACT_DEC: begin
        if (sum[32] != sum[31]) begin
          ctrl_d.res    = sum[32] ? MIN_RAW : MAX_RAW;
          ctrl_d.status = ST_SAT;
        end else begin
          ctrl_d.res = sum[31:0];
        end
      end
      ACT_MUL: begin
        if (!pneg && rnd > 64'h7FFF_FFFF) begin
          ctrl_d.res    = MAX_RAW;
          ctrl_d.status = ST_SAT;
        end else if (pneg && rnd > 64'h8000_0000) begin
          ctrl_d.res    = MIN_RAW;
          ctrl_d.status = ST_SAT;
        end else begin
          ctrl_d.res = pneg ? -rnd[31:0] : rnd[31:0];
        end
      end
      ACT_DIV: begin
        if (b_a_q == '0) begin
          ctrl_d.status = ST_DIV_ZERO;
        end
      end
      ACT_GT: ctrl_d.flag = a_a_q > b_a_q;
      ACT_LT: ctrl_d.flag = a_a_q < b_a_q;
      ACT_GE: ctrl_d.flag = a_a_q >= b_a_q;
      ACT_LE: ctrl_d.flag = a_a_q <= b_a_q;
      ACT_EQ: ctrl_d.flag = a_a_q == b_a_q;
      ACT_NE: ctrl_d.flag = a_a_q != b_a_q;
      ACT_MIN: ctrl_d.res = (a_a_q < b_a_q) ? a_a_q : b_a_q;
      ACT_MAX: ctrl_d.res = (a_a_q > b_a_q) ? a_a_q : b_a_q;
      ACT_FROM_INT: begin
        if (fi != 64'(fi[31:0]) && fi != 64'(signed'(fi[31:0]))) begin
          ctrl_d.res    = a_a_q[31] ? MIN_RAW : MAX_RAW;
          ctrl_d.status = ST_SAT;
        end else if (fi != 64'(signed'(fi[31:0]))) begin
          ctrl_d.res    = a_a_q[31] ? MIN_RAW : MAX_RAW;
          ctrl_d.status = ST_SAT;
        end else begin
          ctrl_d.res = fi[31:0];
        end
      end
      ACT_TO_INT: ctrl_d.res = a_a_q >>> FRAC_BITS;
      default: ctrl_d.res = '0;
    endcase
  end

  // Register stage B with the divider start values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q  <= NW'(amag_a_q) << FRAC_BITS;
      nb_q <= bmag_a_q;
    end
  end

  assign ctrl_o = ctrl_q;
  assign w_o    = w_q;
  assign nb_o   = nb_q;

endmodule

/* rtl/fpa_div_stage.sv */
// One registered restoring-division step: one quotient bit per stage.
// Depends on fpa_pkg.
`timescale 1ns / 1ps

module fpa_div_stage import fpa_pkg::*; #(
  parameter int NW = 40
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  fpa_ctrl_t     ctrl_i,
  input  logic [NW-1:0] w_i,
  input  logic [31:0]   rem_i,
  input  logic [31:0]   nb_i,
  output fpa_ctrl_t     ctrl_o,
  output logic [NW-1:0] w_o,
  output logic [31:0]   rem_o,
  output logic [31:0]   nb_o
);

  fpa_ctrl_t     ctrl_q;
  logic [NW-1:0] w_q;
  logic [31:0]   rem_q, nb_q;
  logic [32:0]   trial, diff;
  logic          ge;

  // Bring down the next dividend bit and trial-subtract
  assign trial = {rem_i, w_i[NW-1]};
  assign diff  = trial - {1'b0, nb_i};
  assign ge    = trial >= {1'b0, nb_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  // Shift the quotient bit in as the dividend bit leaves
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q   <= {w_i[NW-2:0], ge};
      rem_q <= ge ? diff[31:0] : trial[31:0];
      nb_q  <= nb_i;
    end
  end

  assign ctrl_o = ctrl_q;
  assign w_o    = w_q;
  assign rem_o  = rem_q;
  assign nb_o   = nb_q;

endmodule

/* rtl/fpa_back.sv */
// Output stage: rounds and saturates the quotient and holds the result.
// Depends on fpa_pkg.
`timescale 1ns / 1ps

module fpa_back import fpa_pkg::*; #(
  parameter int NW = 40
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  fpa_ctrl_t     ctrl_i,
  input  logic [NW-1:0] q_i,
  input  logic [31:0]   rem_i,
  input  logic [31:0]   nb_i,
  output fpa_ctrl_t     ctrl_o
);

  localparam logic [NW:0] POS_LIM = (NW+1)'(32'h7FFF_FFFF);
  localparam logic [NW:0] NEG_LIM = (NW+1)'(33'h0_8000_0000);

  fpa_ctrl_t   ctrl_d, ctrl_q;
  logic        up;
  logic [NW:0] qr;

  // Round half away from zero: bump when twice the remainder reaches the divisor
  assign up = {rem_i, 1'b0} >= {1'b0, nb_i};
  assign qr = (NW+1)'(q_i) + (NW+1)'(up);

  always_comb begin
    ctrl_d = ctrl_i;
    if (ctrl_i.action == ACT_DIV && ctrl_i.status != ST_DIV_ZERO) begin
      if (!ctrl_i.neg && qr > POS_LIM) begin
        ctrl_d.res    = MAX_RAW;
        ctrl_d.status = ST_SAT;
      end else if (ctrl_i.neg && qr > NEG_LIM) begin
        ctrl_d.res    = MIN_RAW;
        ctrl_d.status = ST_SAT;
      end else begin
        ctrl_d.res = ctrl_i.neg ? -qr[31:0] : qr[31:0];
      end
    end
  end

  // Hold the finished item until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (en_i) begin
      ctrl_q <= ctrl_d;
    end
  end

  assign ctrl_o = ctrl_q;

endmodule

/* rtl/fixed_point_q24_8_alu_unit.sv */
// Top level of the signed fixed-point ALU: front stages, divider chain, output.
// Depends on fpa_pkg, fpa_if, fpa_front, fpa_div_stage, fpa_back and the macros.
//
// Usage: each item on in_i carries an action and two raw operands; each item
// on out_o carries the raw result, a compare flag and a status (0 ok,
// 1 division by zero, 2 saturated). Every item gives exactly one result,
// in order.
// Depth: FRAC_BITS + 35 register stages (43 at the default Q24.8), the same
// for every action. The depth is set by the restoring divider, one quotient
// bit per stage over a 32 + FRAC_BITS bit dividend.
// Throughput: one item per cycle; every stage registers and passes an item
// each cycle while the output is free or being taken.
// Reset: all valid bits clear at once; the pipeline is empty after reset.
// Stall: while out_o.valid is high and out_o.ready low the whole pipeline
// holds, in_i.ready drops, and the output payload stays unchanged.
`timescale 1ns / 1ps
`include "fixed_point_q24_8_alu_unit_macros.svh"

module fixed_point_q24_8_alu_unit import fpa_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fpa_in_if.sink    in_i,
  fpa_out_if.source out_o
);

  localparam int NW = 32 + FRAC_BITS;

  logic en;
  fpa_ctrl_t     ctrl_s [NW+1];
  logic [NW-1:0] w_s    [NW+1];
  logic [31:0]   rem_s  [NW+1];
  logic [31:0]   nb_s   [NW+1];
  fpa_ctrl_t     ctrl_out;

  // Advance everything unless a held result is not being taken
  assign en       = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  fpa_front #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_i.valid),
    .action_i (in_i.action),
    .a_i      (in_i.operand_a),
    .b_i      (in_i.operand_b),
    .ctrl_o   (ctrl_s[0]),
    .w_o      (w_s[0]),
    .nb_o     (nb_s[0])
  );

  assign rem_s[0] = '0;

  // Divider chain
  for (genvar i = 0; i < NW; i++) begin : g_div
    fpa_div_stage #(.NW(NW)) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctrl_i (ctrl_s[i]),
      .w_i    (w_s[i]),
      .rem_i  (rem_s[i]),
      .nb_i   (nb_s[i]),
      .ctrl_o (ctrl_s[i+1]),
      .w_o    (w_s[i+1]),
      .rem_o  (rem_s[i+1]),
      .nb_o   (nb_s[i+1])
    );
  end

  fpa_back #(.NW(NW)) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .ctrl_i (ctrl_s[NW]),
    .q_i    (w_s[NW]),
    .rem_i  (rem_s[NW]),
    .nb_i   (nb_s[NW]),
    .ctrl_o (ctrl_out)
  );

  assign out_o.valid        = ctrl_out.valid;
  assign out_o.result_raw   = ctrl_out.res;
  assign out_o.compare_flag = ctrl_out.flag;
  assign out_o.status       = ctrl_out.status;

  `FPA_ASSERT_OUT(a_divzero_zero, (out_o.status != ST_DIV_ZERO || out_o.result_raw == '0), "division by zero must give a zero result")
  `FPA_ASSERT_OUT(a_flag_clean, (!out_o.compare_flag || (out_o.status == ST_OK && out_o.result_raw == '0)), "compare flag set with a nonzero result or status")
  `FPA_ASSERT_OUT(a_sat_bound, (out_o.status != ST_SAT || out_o.result_raw == MAX_RAW || out_o.result_raw == MIN_RAW), "saturated result not at a bound")

endmodule
